// ===== hw/rtl/mtlm_pkg.sv =====
// media type list matcher: shared types, constants and helper functions
// used by the cell chain, the top level and the checkers
// no dependencies
`timescale 1ns / 1ps

package mtlm_pkg;

    localparam int NUM_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int STORE_DEPTH     = NUM_PATTERNS * MAX_PATTERN_LEN;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int SLOT_W          = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int STEP_W          = SLOT_W + 1;

    // fixed widths of the stream and register fields
    localparam int CNT_W        = 4;
    localparam int POS_W        = 6;
    localparam int SLOT_FIELD_W = 3;
    localparam int APB_AW       = 3;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // register index bit of paddr
    localparam logic REG_IDX_PATTERN_COUNT = 1'b0;

    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam int LEN_MULTIPART = 9;
    localparam int LEN_MESSAGE   = 7;
    localparam logic [8*LEN_MULTIPART-1:0] FIX_MULTIPART = "multipart";
    localparam logic [8*LEN_MESSAGE-1:0]   FIX_MESSAGE   = "message";

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_CHAR    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_PATTERN   = 2'd1,
        KIND_MULTIPART = 2'd2,
        KIND_MESSAGE   = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // token handed from cell to cell during one scan
    typedef struct packed {
        logic              valid;
        logic [7:0]        ch;
        logic              past;   // position beyond the slot length
        logic              done;   // a slot already hit
        logic              any;    // some slot stays alive
        logic [SLOT_W-1:0] last;   // last slot examined
    } t_tok;

    // byte of a fixed type: inr low past the terminator
    typedef struct packed {
        logic       inr;
        logic [7:0] b;
    } t_fix;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
    endfunction

    function automatic t_fix fixed_byte(input logic which, input logic [POS_W-1:0] pos);
        t_fix r;
        int   p;
        int   len;
        p     = int'(pos);
        len   = which ? LEN_MESSAGE : LEN_MULTIPART;
        r.inr = 1'b1;
        r.b   = CH_NUL;
        if (p < len) begin
            if (which) begin
                r.b = FIX_MESSAGE[8*(LEN_MESSAGE-1-p) +: 8];
            end else begin
                r.b = FIX_MULTIPART[8*(LEN_MULTIPART-1-p) +: 8];
            end
        end else if (p > len) begin
            r.inr = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [POS_W-1:0] pos);
        int a;
        a = int'(slot) * MAX_PATTERN_LEN + int'(pos);
        return ADDR_W'(a);
    endfunction

endpackage

// ===== hw/rtl/mtlm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mtlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mtlm_cell.sv =====
// one pattern slot of the matcher chain: alive bit and registered token stage
// depends on mtlm_pkg
`timescale 1ns / 1ps

module mtlm_cell import mtlm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_index,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_restart,
    input  logic [7:0]        i_rdata,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    logic r_alive;
    logic n_alive;
    t_tok r_tok;
    t_tok n_tok;

    always_comb begin
        logic active;
        logic star;
        logic term;
        n_tok   = i_tok;
        n_alive = r_alive;
        active  = i_tok.valid && !i_tok.done && r_alive && (int'(i_index) < int'(i_count));
        star    = !i_tok.past && (i_rdata == CH_STAR);
        term    = !i_tok.past && ((i_tok.ch == CH_SEMI) || is_ws(i_tok.ch)) &&
                  ((i_rdata == CH_NUL) || (i_rdata == CH_COMMA));
        if (active) begin
            n_tok.last = i_index;
            if (star || term) begin
                n_tok.done = 1'b1;
            end else if (i_tok.past || (i_rdata == CH_NUL) || (i_rdata == CH_COMMA) ||
                         (i_rdata != i_tok.ch)) begin
                n_alive = 1'b0;
            end else begin
                n_tok.any = 1'b1;
            end
        end
        if (i_restart) begin
            n_alive = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b1;
            r_tok   <= '0;
        end else begin
            r_alive <= n_alive;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/media_type_list_matcher.sv =====
// media type list matcher top level: stream ports, apb register, sequencer,
// fixed type match and output register
// depends on mtlm_pkg, mtlm_ram, mtlm_cell
//
// channel   | dir | handshake                 | payload
// ----------+-----+---------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready      | tuser req_type; tdata slot, pos, char
// m_axis    | out | m_axis_tvalid/tready      | tdata still_matching, match_kind, slot
// apb       | in  | psel/penable/pwrite/pready| pattern_count at byte address 0
//
// a header character that is matched goes from accept to result through one ram read
// per slot, the token walking the cell chain, and the output register
// load, restart, none requests, skipped and comment characters give their result in the next cycle
// s_axis_tready is low while a character walks the chain or a result is stuck
// synchronous active low reset; no clearing pass, the pattern store is undefined
// until loaded
`timescale 1ns / 1ps

module media_type_list_matcher import mtlm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [2:0] pattern_slot, [7:3] char_pos,
                                              // [15:8] char_value
    input  logic [1:0]        s_axis_tuser,   // [1:0] req_type
    // stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] still_matching, [2:1] match_kind,
                                              // [5:3] matched_slot, [7:6] zero
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // input fields
    t_req       w_req;
    logic [2:0] w_slot;
    logic [4:0] w_pos;
    logic [7:0] w_ch;

    assign w_req  = t_req'(s_axis_tuser);
    assign w_slot = s_axis_tdata[2:0];
    assign w_pos  = s_axis_tdata[7:3];
    assign w_ch   = s_axis_tdata[15:8];

    // configuration register
    logic [CNT_W-1:0] r_count;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[APB_AW-1] == REG_IDX_PATTERN_COUNT);
    assign prdata   = (paddr[APB_AW-1] == REG_IDX_PATTERN_COUNT) ? 32'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_cfg_wr) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    // matcher state
    t_state            r_state, n_state;
    logic              r_in_comment, n_in_comment;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_kind             r_kind, n_kind;
    logic [SLOT_W-1:0] r_last, n_last;
    logic [1:0]        r_xalive, n_xalive;
    logic [STEP_W-1:0] r_step, n_step;
    t_tok              r_tok0, n_tok0;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_hit, n_out_hit;
    t_kind                   r_out_kind, n_out_kind;
    logic [SLOT_FIELD_W-1:0] r_out_slot, n_out_slot;

    // pattern store and chain
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_rdata;
    logic              w_restart;
    logic              w_s_acc;
    t_tok              w_tok [0:NUM_PATTERNS];

    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_restart     = w_s_acc && (w_req == REQ_RESTART);

    mtlm_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_ch),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_tok[0] = r_tok0;

    // one cell per slot; the token reaches cell g together with the byte of slot g
    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
        mtlm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (SLOT_W'(g)),
            .i_count   (r_count),
            .i_restart (w_restart),
            .i_rdata   (w_rdata),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    always_comb begin
        t_tok v_tok;
        t_fix v_fb;
        logic v_xhit;
        n_state      = r_state;
        n_in_comment = r_in_comment;
        n_pos        = r_pos;
        n_kind       = r_kind;
        n_last       = r_last;
        n_xalive     = r_xalive;
        n_step       = r_step;
        n_tok0       = '0;
        n_out_valid  = r_out_valid;
        n_out_hit    = r_out_hit;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        w_we         = 1'b0;
        w_waddr      = store_addr(SLOT_W'(w_slot), POS_W'(w_pos));
        w_re         = 1'b0;
        w_raddr      = store_addr(r_step[SLOT_W-1:0], r_pos);
        v_tok        = w_tok[NUM_PATTERNS];
        v_fb         = '0;
        v_xhit       = 1'b0;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    // default result: no hit, current kind and slot
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_kind  = r_kind;
                    n_out_slot  = SLOT_FIELD_W'(r_last);
                    case (w_req)
                        REQ_LOAD: begin
                            w_we = (int'(w_slot) < NUM_PATTERNS) &&
                                   (int'(w_pos) < MAX_PATTERN_LEN);
                        end
                        REQ_RESTART: begin
                            n_in_comment = 1'b0;
                            n_pos        = '0;
                            n_kind       = KIND_NONE;
                            n_last       = '0;
                            n_xalive     = '1;
                            n_out_kind   = KIND_NONE;
                            n_out_slot   = '0;
                        end
                        REQ_CHAR: begin
                            if (r_in_comment) begin
                                if (w_ch == CH_RPAREN) begin
                                    n_in_comment = 1'b0;
                                end
                            end else if (w_ch == CH_LPAREN) begin
                                n_in_comment = 1'b1;
                            end else if (w_ch != CH_SPACE) begin
                                // launch the token; byte of slot 0 arrives next cycle
                                n_out_valid  = r_out_valid && !m_axis_tready;
                                n_tok0.valid = 1'b1;
                                n_tok0.ch    = w_ch;
                                n_tok0.past  = int'(r_pos) >= MAX_PATTERN_LEN;
                                n_tok0.last  = r_last;
                                w_re         = 1'b1;
                                w_raddr      = store_addr('0, r_pos);
                                n_step       = STEP_W'(1);
                                n_state      = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // fetch the byte for the next cell down the chain
                if (int'(r_step) < NUM_PATTERNS) begin
                    w_re   = 1'b1;
                    n_step = r_step + STEP_W'(1);
                end
                if (v_tok.valid) begin
                    n_last  = v_tok.last;
                    n_state = ST_IDLE;
                    if (v_tok.done) begin
                        // a slot hit on star or on the end of its pattern
                        n_kind    = KIND_PATTERN;
                        n_out_hit = 1'b1;
                    end else begin
                        // fixed types multipart and message
                        for (int k = 0; k < 2; k++) begin
                            if (r_xalive[k]) begin
                                v_fb = fixed_byte(k[0], r_pos);
                                if (v_fb.inr && (v_fb.b == v_tok.ch)) begin
                                    v_xhit = 1'b1;
                                end else if (v_fb.inr && (v_fb.b == CH_NUL) &&
                                             (v_tok.ch == CH_SLASH)) begin
                                    n_kind = k[0] ? KIND_MESSAGE : KIND_MULTIPART;
                                end else begin
                                    n_xalive[k] = 1'b0;
                                end
                            end
                        end
                        n_out_hit = v_tok.any || v_xhit;
                        if ((v_tok.any || v_xhit) && (r_pos != POS_MAX)) begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out_kind  = n_kind;
                    n_out_slot  = SLOT_FIELD_W'(v_tok.last);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_in_comment <= 1'b0;
            r_pos        <= '0;
            r_kind       <= KIND_NONE;
            r_last       <= '0;
            r_xalive     <= '1;
            r_step       <= '0;
            r_tok0       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_in_comment <= n_in_comment;
            r_pos        <= n_pos;
            r_kind       <= n_kind;
            r_last       <= n_last;
            r_xalive     <= n_xalive;
            r_step       <= n_step;
            r_tok0       <= n_tok0;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_hit  <= n_out_hit;
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_slot, r_out_kind, r_out_hit};

endmodule

// ===== hw/rtl/mtlm_chk.sv =====
// port level checker for the media type list matcher, bound to the top level
// depends on mtlm_pkg and media_type_list_matcher
`timescale 1ns / 1ps

module mtlm_chk import mtlm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [1:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [7:0]        m_axis_tdata,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // restart gives a cleared result right away
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_RESTART))
        |=> (m_axis_tvalid && (m_axis_tdata[5:0] == 6'd0)))
        else $error("restart result not cleared");

    // a load never reports a match
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD))
        |=> (m_axis_tvalid && !m_axis_tdata[0]))
        else $error("load transaction reported a match");

    // written pattern count reads back
    a_cfg_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_IDX_PATTERN_COUNT))
        |=> ((paddr[APB_AW-1] != REG_IDX_PATTERN_COUNT) ||
             (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]))))
        else $error("pattern count readback mismatch");

endmodule

bind media_type_list_matcher mtlm_chk u_mtlm_chk (.*);

// ===== sim/mtlm_checker.sv =====
// checker for the media type list matcher: watches the stream and register ports,
// predicts every result transaction and compares it field by field
// depends on mtlm_pkg
`timescale 1ns / 1ps

module mtlm_checker import mtlm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [2:0] pattern_slot, [7:3] char_pos,
                                              // [15:8] char_value
    input  logic [1:0]        s_axis_tuser,   // [1:0] req_type
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,   // [0] still_matching, [2:1] match_kind,
                                              // [5:3] matched_slot
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic       hit;
        t_kind      kind;
        logic [2:0] slot;
    } t_outcome;

    localparam logic [APB_AW-1:0] COUNT_ADDR = {REG_IDX_PATTERN_COUNT, 2'b00};
    localparam logic [8*9-1:0]    NAME_MP    = "multipart";
    localparam logic [8*7-1:0]    NAME_MSG   = "message";

    // mirror of the matcher state
    logic [7:0]              pat_bytes [STORE_DEPTH];
    logic [NUM_PATTERNS-1:0] slot_live;
    logic [1:0]              type_live;
    logic                    in_paren;
    logic [POS_W-1:0]        col;
    t_kind                   kind_seen;
    logic [2:0]              slot_seen;
    logic [3:0]              slots_used;

    t_outcome expected_results [$];

    function automatic logic is_ctl_blank(input logic [7:0] c);
        return c >= 8'd9 && c <= 8'd13;
    endfunction

    // byte of a fixed type name: -1 past its end, 0 right at its end
    function automatic int type_char(input int k, input int p);
        int n;
        n = (k == 0) ? 9 : 7;
        if (p > n) return -1;
        if (p == n) return 0;
        return (k == 0) ? int'(NAME_MP[8*(8-p) +: 8]) : int'(NAME_MSG[8*(6-p) +: 8]);
    endfunction

    task automatic clear_scan();
        slot_live = '1;
        type_live = '1;
        in_paren  = 1'b0;
        col       = '0;
        kind_seen = KIND_NONE;
        slot_seen = '0;
    endtask

    task automatic scan_char(input logic [7:0] c, output logic hit);
        int         n;
        int         fb;
        logic [7:0] b;
        logic       past;
        logic       any_slot;
        logic       any_type;
        logic       done;
        n        = (slots_used > NUM_PATTERNS) ? NUM_PATTERNS : int'(slots_used);
        any_slot = 1'b0;
        any_type = 1'b0;
        done     = 1'b0;
        hit      = 1'b0;
        for (int i = 0; i < n && !done; i++) begin
            if (slot_live[i]) begin
                slot_seen = 3'(i);
                past = (col >= MAX_PATTERN_LEN);
                b    = past ? CH_NUL : pat_bytes[i*MAX_PATTERN_LEN + int'(col)];
                if (!past && b == CH_STAR) begin
                    done = 1'b1;
                end else if (!past && (c == CH_SEMI || is_ctl_blank(c))
                             && (b == CH_NUL || b == CH_COMMA)) begin
                    done = 1'b1;
                end else if (past || b == CH_NUL || b == CH_COMMA || b != c) begin
                    slot_live[i] = 1'b0;
                end else begin
                    any_slot = 1'b1;
                end
            end
        end
        if (done) begin
            // first slot hit ends the scan, fixed types and column untouched
            kind_seen = KIND_PATTERN;
            hit       = 1'b1;
        end else begin
            for (int k = 0; k < 2; k++) begin
                if (type_live[k]) begin
                    fb = type_char(k, int'(col));
                    if (fb >= 0 && fb == int'(c)) begin
                        any_type = 1'b1;
                    end else if (fb == 0 && c == CH_SLASH) begin
                        kind_seen = (k == 0) ? KIND_MULTIPART : KIND_MESSAGE;
                    end else begin
                        type_live[k] = 1'b0;
                    end
                end
            end
            if (any_slot || any_type) begin
                if (col != POS_MAX) col = col + 1'b1;
                hit = 1'b1;
            end
        end
    endtask

    task automatic take_request(input t_req req, input logic [2:0] slot,
                                input logic [4:0] pos, input logic [7:0] ch,
                                output t_outcome r);
        logic hit;
        hit = 1'b0;
        case (req)
            REQ_LOAD: begin
                pat_bytes[int'(slot)*MAX_PATTERN_LEN + int'(pos)] = ch;
            end
            REQ_RESTART: begin
                clear_scan();
            end
            REQ_CHAR: begin
                if (in_paren) begin
                    if (ch == CH_RPAREN) in_paren = 1'b0;
                end else if (ch == CH_LPAREN) begin
                    in_paren = 1'b1;
                end else if (ch != CH_SPACE) begin
                    scan_char(ch, hit);
                end
            end
            default: ;
        endcase
        r.hit  = hit;
        r.kind = kind_seen;
        r.slot = slot_seen;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            clear_scan();
            slots_used = '0;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite && paddr == COUNT_ADDR) begin
                    slots_used = pwdata[3:0];
                end else if (!pwrite && prdata != {28'd0, slots_used}) begin
                    $error("prdata: expected %0d, got %0d", slots_used, prdata);
                    o_errors++;
                end
            end
            // result side first: a result never belongs to a request of the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit  = m_axis_tdata[0];
                got.kind = t_kind'(m_axis_tdata[2:1]);
                got.slot = m_axis_tdata[5:3];
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_axis_tdata);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit != want.hit) begin
                        $error("still_matching: expected %0d, got %0d", want.hit, got.hit);
                        o_errors++;
                    end
                    if (got.kind != want.kind) begin
                        $error("match_kind: expected %0d, got %0d", want.kind, got.kind);
                        o_errors++;
                    end
                    if (got.slot != want.slot) begin
                        $error("matched_slot: expected %0d, got %0d", want.slot, got.slot);
                        o_errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_request(t_req'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[7:3],
                             s_axis_tdata[15:8], want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the media type list matcher: clock, reset, stimulus with
// idling phases and the final verdict
// depends on mtlm_pkg, media_type_list_matcher and mtlm_checker
`timescale 1ns / 1ps

module tb_top import mtlm_pkg::*; ();

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 110;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 12;   // a bit above the character latency
    localparam logic [APB_AW-1:0] COUNT_ADDR = {REG_IDX_PATTERN_COUNT, 2'b00};

    // per phase settings: count register, sender idle and receiver stall percentages
    localparam logic [3:0] PHASE_COUNT [PHASES] = '{4'd8, 4'd0, 4'd15, 4'd1,
                                                    4'd5, 4'd8, 4'd9, 4'd3};
    localparam int TX_IDLE  [4] = '{0, 57, 0, 36};
    localparam int RX_STALL [4] = '{0, 0, 57, 36};

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic [15:0]       s_axis_tdata  = '0;
    logic [1:0]        s_axis_tuser  = '0;
    logic              m_axis_tready = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [7:0]        m_axis_tdata;
    logic [31:0]       prdata;
    logic              pready;

    int    errors;
    int    pending;
    int    tx_idle_pct  = 0;
    int    rx_stall_pct = 0;
    int    holds_asked  = 0;
    int    holds_served = 0;
    int    hold_left    = 0;
    int    items_sent   = 0;
    string slot_text [NUM_PATTERNS];

    always #1 i_clk = ~i_clk;

    media_type_list_matcher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mtlm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // run limit
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("tb_top: errors");
        $finish;
    end

    // receiver: random stalls per phase, plus a long hold-off when asked for
    always @(negedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_pct > 0) begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one input transaction; entered and left right after a falling edge
    task automatic send(input t_req req, input logic [2:0] slot, input logic [4:0] pos,
                        input logic [7:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {ch, pos, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // header character; slot and position are don't-care, so they get random bits
    task automatic send_char(input logic [7:0] ch);
        send(REQ_CHAR, 3'($urandom_range(7)), 5'($urandom_range(31)), ch);
    endtask

    task automatic send_string(input string t);
        for (int i = 0; i < t.len(); i++) send_char(t[i]);
    endtask

    // bring the block back to idle and let the last character drain out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= COUNT_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic string stock_type(input int idx);
        case (idx)
            0:       return "text/plain";
            1:       return "text/*";
            2:       return "image/png";
            3:       return "application/json,text/x";
            4:       return "audio/*";
            5:       return "video/mp4";
            6:       return "message/rfc822";
            7:       return "multipart/mixed";
            8:       return "*";
            9:       return "text/html";
            10:      return "application/pdf";
            11:      return "multi";
            default: return "mess";
        endcase
    endfunction

    // random pattern; a quarter fill the whole slot with no terminator
    function automatic string random_pattern();
        string      s;
        int         n;
        logic [7:0] ch;
        n = ($urandom_range(3) == 0) ? MAX_PATTERN_LEN : $urandom_range(MAX_PATTERN_LEN - 1, 1);
        s = "";
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0:       ch = CH_STAR;
                1:       ch = CH_COMMA;
                2:       ch = CH_SLASH;
                default: ch = 8'h61 + 8'($urandom_range(25));
            endcase
            s = {s, "-"};
            s.putc(i, ch);
        end
        return s;
    endfunction

    // header text aimed at a loaded slot, a fixed type or nothing in particular
    function automatic string pick_header();
        string t;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: t = slot_text[$urandom_range(NUM_PATTERNS - 1)];
            6:                t = "multipart";
            7:                t = "message";
            8:                t = random_pattern();
            default: begin
                t = slot_text[$urandom_range(NUM_PATTERNS - 1)];
                t = t.substr(0, $urandom_range(t.len() - 1));
            end
        endcase
        return t;
    endfunction

    // load a pattern, ended by nul or comma when it is shorter than the slot
    task automatic load_text(input logic [2:0] slot, input string t);
        int n;
        n = t.len();
        for (int i = 0; i < n && i < MAX_PATTERN_LEN; i++) send(REQ_LOAD, slot, 5'(i), t[i]);
        if (n < MAX_PATTERN_LEN)
            send(REQ_LOAD, slot, 5'(n), ($urandom_range(3) == 0) ? CH_COMMA : CH_NUL);
        slot_text[slot] = t;
    endtask

    // restart, then the header with stray spaces, comments and mutated characters
    task automatic send_header(input string t, input int noise_pct);
        logic [7:0] ch;
        send(REQ_RESTART, 3'($urandom_range(7)), 5'($urandom_range(31)),
             8'($urandom_range(255)));
        for (int i = 0; i < t.len(); i++) begin
            if ($urandom_range(99) < 8) send_char(CH_SPACE);
            if ($urandom_range(99) < 5) begin
                send_char(CH_LPAREN);
                repeat ($urandom_range(3)) send_char(8'($urandom_range(255)));
                send_char(CH_RPAREN);
            end
            ch = t[i];
            if ($urandom_range(99) < noise_pct) ch = 8'($urandom_range(255));
            send_char(ch);
        end
        case ($urandom_range(9))
            0, 1:          ch = CH_SEMI;
            2, 3, 4, 5, 6: ch = 8'd9 + 8'($urandom_range(4));
            7:             ch = CH_SLASH;
            8:             ch = 8'($urandom_range(255));
            default:       ch = CH_NUL;
        endcase
        send_char(ch);
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(6, 1)) send_char(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int    target;
        int    r;
        string t;
        logic  paused;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        reg_access(1'b1, 32'd8);
        reg_access(1'b0, 32'd0);

        // fill the whole store once, every slot with a stock type and nul padding
        for (int s = 0; s < NUM_PATTERNS; s++) begin
            t = stock_type(s);
            slot_text[s] = t;
            for (int p = 0; p < MAX_PATTERN_LEN; p++)
                send(REQ_LOAD, 3'(s), 5'(p), (p < t.len()) ? t[p] : CH_NUL);
        end

        // directed: comment skip into a fixed type, a slot hit on ';', unused code,
        // a top-bit character
        send(REQ_RESTART, 3'd0, 5'd0, 8'h00);
        send_string("( )multipart/");
        send(REQ_RESTART, 3'd7, 5'd31, 8'hff);
        send_string("image/png;");
        send(REQ_NONE, 3'd7, 5'd31, 8'hff);
        send_char(8'hff);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_idle_pct  = TX_IDLE[ph % 4];
            rx_stall_pct = RX_STALL[ph % 4];
            reg_access(1'b1, {28'($urandom_range(32'h0fff_ffff)), PHASE_COUNT[ph]});
            reg_access(1'b0, 32'd0);
            // long receiver hold-off while the sender keeps pushing
            if (ph == 4) holds_asked++;
            paused = 1'b0;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if (ph == 5 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                if (r < 55) begin
                    send_header(pick_header(), 3);
                end else if (r < 65) begin
                    load_text(3'($urandom_range(NUM_PATTERNS - 1)),
                              ($urandom_range(1) == 0) ? stock_type($urandom_range(12))
                                                       : random_pattern());
                end else if (r < 80) begin
                    send(t_req'($urandom_range(3)), 3'($urandom_range(7)),
                         5'($urandom_range(31)), 8'($urandom_range(255)));
                end else begin
                    // broken sequence: heavily mutated header
                    send_header(pick_header(), 40);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
